// ----- sv/tpcc_pkg.sv -----
// Shared types, constants and helpers for the two-point crosshair calibrator.
// Used by tpcc_div and two_point_crosshair_calibrator; depends on nothing.
`timescale 1ns / 1ps

package tpcc_pkg;

  // Fraction bits of the interpolation weight.
  localparam int FRAC_BITS = 14;

  // Position width and difference width (one extra bit for the sign of a span).
  localparam int XW = 16;
  localparam int DW = XW + 1;

  // Multiplier operand A holds a difference or a clamped weight.
  localparam int MA_W  = (FRAC_BITS + 2 > DW) ? FRAC_BITS + 2 : DW;
  // Product and dividend width; quotient and wide sum widths.
  localparam int NUM_W = MA_W + DW;
  localparam int QUO_W = NUM_W + 1;
  localparam int SUM_W = NUM_W + 2;
  localparam int CNT_W = $clog2(NUM_W + 1);

  // Weight clamp limits: -0.25 and 1.25.
  localparam logic signed [QUO_W-1:0] FRAC_LO = QUO_W'(-(1 << (FRAC_BITS - 2)));
  localparam logic signed [QUO_W-1:0] FRAC_HI =
    QUO_W'((1 << FRAC_BITS) + (1 << (FRAC_BITS - 2)));

  // Half an LSB of the weight, for rounding the weighted span.
  localparam logic [NUM_W-1:0] RND_HALF = NUM_W'(1) << (FRAC_BITS - 1);

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

  // Register reset values.
  localparam logic signed [XW-1:0] NEAR_Y_RST = XW'(1638);
  localparam logic signed [XW-1:0] FAR_Y_RST  = XW'(-11469);

  // Register index, taken from paddr[2].
  localparam logic REG_NEAR_Y = 1'b0;
  localparam logic REG_FAR_Y  = 1'b1;

  typedef enum logic {
    CMD_CALIBRATE = 1'b0,
    CMD_QUERY     = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_UPD_START,
    ST_UPD_WAIT,
    ST_FRAC_START,
    ST_FRAC_WAIT,
    ST_ROUND,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DW-1:0]    den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [XW-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [XW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[XW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[XW-1:0];
    end else begin
      r = v[XW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/tpcc_div.sv -----
// Signed radix-2 restoring divider, rounding to nearest with ties away from zero.
// Depends on tpcc_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module tpcc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpcc_pkg::div_req_t req_i,
  output tpcc_pkg::div_rsp_t rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [tpcc_pkg::CNT_W-1:0]    cnt_q;
  logic [tpcc_pkg::NUM_W-1:0]    dvd_q;
  logic [tpcc_pkg::XW-1:0]       rem_q;
  logic [tpcc_pkg::XW-1:0]       dsr_q;
  logic                          neg_q;

  logic [tpcc_pkg::NUM_W-1:0]    num_mag;
  logic [tpcc_pkg::DW-1:0]       den_abs;
  logic [tpcc_pkg::XW:0]         shifted;
  logic [tpcc_pkg::XW+1:0]       trial;
  logic                          ge;
  logic [tpcc_pkg::XW-1:0]       rem_d;

  always_comb begin
    num_mag = req_i.num[tpcc_pkg::NUM_W-1] ? -req_i.num : req_i.num;
    den_abs = req_i.den[tpcc_pkg::DW-1] ? -req_i.den : req_i.den;
    shifted = {rem_q, dvd_q[tpcc_pkg::NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dsr_q};
    ge      = ~trial[tpcc_pkg::XW+1];
    rem_d   = ge ? trial[tpcc_pkg::XW-1:0] : shifted[tpcc_pkg::XW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= tpcc_pkg::CNT_W'(tpcc_pkg::NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - tpcc_pkg::CNT_W'(1);
        if (cnt_q == tpcc_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Bias the dividend by half the divisor, then shift quotient bits in.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dsr_q <= den_abs[tpcc_pkg::XW-1:0];
      dvd_q <= num_mag + tpcc_pkg::NUM_W'(den_abs[tpcc_pkg::XW-1:1]);
      rem_q <= '0;
      neg_q <= req_i.num[tpcc_pkg::NUM_W-1] ^ req_i.den[tpcc_pkg::DW-1];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[tpcc_pkg::NUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    rsp_o.quot = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
  end

endmodule

// ----- sv/two_point_crosshair_calibrator.sv -----
// Two-point crosshair calibrator: endpoint state, sequencer, shared multiplier.
// Depends on tpcc_pkg and instantiates the shared divider tpcc_div.
`timescale 1ns / 1ps

// The block holds two crosshair X endpoints, near_x at line near_y and far_x
// at line far_y, all signed Q2.14, both endpoints zero after reset. A query
// word (command 1) returns X at target_y by linear interpolation with the
// weight clamped to -0.25..1.25; a calibrate word (command 0) first moves
// the near endpoint (target strictly above the midpoint of the two lines)
// or else the far endpoint so the line passes through the target, then
// reports X at target_y. Every input word yields exactly one result word
// carrying the interpolated X and both endpoints. One word is in flight at
// a time: in_stall_o stays high from acceptance until the result is loaded
// into the output register, which then waits for out_stall_i independently.
// Each quotient runs through one shared 34-step radix-2 divider: a query
// runs only the weight division, a calibrate the endpoint update division
// and then the weight division (a calibrate with a zero divisor skips its
// update; equal lines skip the weight division). near_y and far_y sit at
// APB byte addresses 0 and 4; write them only while the block is idle.

module two_point_crosshair_calibrator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [15:0] target_x_i,
  input  logic [15:0] target_y_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] crosshair_x_o,
  output logic [15:0] near_endpoint_o,
  output logic [15:0] far_endpoint_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int XW    = tpcc_pkg::XW;
  localparam int DW    = tpcc_pkg::DW;
  localparam int NUM_W = tpcc_pkg::NUM_W;
  localparam int SUM_W = tpcc_pkg::SUM_W;
  localparam int MA_W  = tpcc_pkg::MA_W;
  localparam int QUO_W = tpcc_pkg::QUO_W;

  tpcc_pkg::state_e state_q, state_d;

  // configuration and endpoint state
  logic signed [XW-1:0] near_y_q, far_y_q;
  logic signed [XW-1:0] near_x_q, far_x_q;

  // latched input word and working registers
  tpcc_pkg::cmd_e       cmd_q;
  logic signed [XW-1:0] tx_q, ty_q;
  logic                 side_q;     // high: near endpoint moves
  logic signed [DW-1:0] den_q;
  logic signed [NUM_W-1:0] prod_q;
  logic signed [XW-1:0] res_q;

  // output register
  logic                 out_valid_q;
  logic signed [XW-1:0] out_x_q, out_near_q, out_far_q;

  tpcc_pkg::div_req_t div_req;
  tpcc_pkg::div_rsp_t div_rsp;

  logic in_acc, cfg_wr, out_load;

  // datapath terms
  logic signed [DW-1:0]    span, den_near, y_off, diff_near, diff_far, dx, den_sel;
  logic signed [DW:0]      ysum, two_ty;
  logic                    side;
  logic signed [NUM_W-1:0] frac_num;
  logic signed [SUM_W-1:0] upd_sum;
  logic signed [XW-1:0]    upd_x;
  logic signed [QUO_W-1:0] frac_c;
  logic [NUM_W-1:0]        prod_mag, prod_rnd;
  logic signed [SUM_W-1:0] wsum, interp_sum;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [DW-1:0]    mul_b;
  logic signed [NUM_W-1:0] mul_p;

  assign in_stall_o = (state_q != tpcc_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == tpcc_pkg::ST_FINISH) && (!out_valid_q || !out_stall_i);

  // ------------------------------------------------------------------
  // APB registers: index from paddr[2], low bits are byte offsets.
  // ------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_y_q <= tpcc_pkg::NEAR_Y_RST;
      far_y_q  <= tpcc_pkg::FAR_Y_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        tpcc_pkg::REG_NEAR_Y: near_y_q <= pwdata[XW-1:0];
        tpcc_pkg::REG_FAR_Y:  far_y_q  <= pwdata[XW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tpcc_pkg::REG_NEAR_Y: prdata = 32'(near_y_q);
      tpcc_pkg::REG_FAR_Y:  prdata = 32'(far_y_q);
      default:              prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Datapath terms, all from registers.
  // ------------------------------------------------------------------
  always_comb begin
    span      = DW'(far_y_q) - DW'(near_y_q);
    den_near  = DW'(far_y_q) - DW'(ty_q);
    y_off     = DW'(ty_q) - DW'(near_y_q);
    diff_near = DW'(far_x_q) - DW'(tx_q);
    diff_far  = DW'(tx_q) - DW'(near_x_q);
    dx        = DW'(far_x_q) - DW'(near_x_q);
    // Exact midpoint test: 2*y > near_y + far_y.
    ysum      = (DW+1)'(near_y_q) + (DW+1)'(far_y_q);
    two_ty    = (DW+1)'(ty_q) <<< 1;
    side      = two_ty > ysum;
    den_sel   = side ? den_near : y_off;
    frac_num  = NUM_W'(y_off) <<< tpcc_pkg::FRAC_BITS;

    // Endpoint update from the rounded quotient.
    if (side_q) begin
      upd_sum = SUM_W'(far_x_q) - SUM_W'(div_rsp.quot);
    end else begin
      upd_sum = SUM_W'(near_x_q) + SUM_W'(div_rsp.quot);
    end
    upd_x = tpcc_pkg::sat16(upd_sum);

    // Clamp the interpolation weight.
    if (div_rsp.quot < tpcc_pkg::FRAC_LO) begin
      frac_c = tpcc_pkg::FRAC_LO;
    end else if (div_rsp.quot > tpcc_pkg::FRAC_HI) begin
      frac_c = tpcc_pkg::FRAC_HI;
    end else begin
      frac_c = div_rsp.quot;
    end

    // Round the weighted span by FRAC_BITS, ties away from zero.
    prod_mag   = prod_q[NUM_W-1] ? -prod_q : prod_q;
    prod_rnd   = (prod_mag + tpcc_pkg::RND_HALF) >> tpcc_pkg::FRAC_BITS;
    wsum       = prod_q[NUM_W-1] ? -$signed(SUM_W'(prod_rnd)) : $signed(SUM_W'(prod_rnd));
    interp_sum = SUM_W'(near_x_q) + wsum;
  end

  // Shared multiplier: difference times span, or weight times endpoint span.
  always_comb begin
    if (state_q == tpcc_pkg::ST_SETUP) begin
      mul_a = MA_W'(side ? diff_near : diff_far);
      mul_b = span;
    end else begin
      mul_a = $signed(frac_c[MA_W-1:0]);
      mul_b = dx;
    end
    mul_p = mul_a * mul_b;
  end

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpcc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    div_req.start = 1'b0;
    div_req.num   = prod_q;
    div_req.den   = den_q;
    case (state_q)
      tpcc_pkg::ST_IDLE: begin
        if (in_acc) state_d = tpcc_pkg::ST_SETUP;
      end
      tpcc_pkg::ST_SETUP: begin
        // Skip the update on a query or a zero divisor.
        if (cmd_q == tpcc_pkg::CMD_CALIBRATE && den_sel != '0) begin
          state_d = tpcc_pkg::ST_UPD_START;
        end else begin
          state_d = tpcc_pkg::ST_FRAC_START;
        end
      end
      tpcc_pkg::ST_UPD_START: begin
        div_req.start = 1'b1;
        state_d       = tpcc_pkg::ST_UPD_WAIT;
      end
      tpcc_pkg::ST_UPD_WAIT: begin
        if (div_rsp.done) state_d = tpcc_pkg::ST_FRAC_START;
      end
      tpcc_pkg::ST_FRAC_START: begin
        // No span: the crosshair sits on the near endpoint.
        if (span == '0) begin
          state_d = tpcc_pkg::ST_FINISH;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = frac_num;
          div_req.den   = span;
          state_d       = tpcc_pkg::ST_FRAC_WAIT;
        end
      end
      tpcc_pkg::ST_FRAC_WAIT: begin
        if (div_rsp.done) state_d = tpcc_pkg::ST_ROUND;
      end
      tpcc_pkg::ST_ROUND: begin
        state_d = tpcc_pkg::ST_FINISH;
      end
      tpcc_pkg::ST_FINISH: begin
        if (out_load) state_d = tpcc_pkg::ST_IDLE;
      end
      default: state_d = tpcc_pkg::ST_IDLE;
    endcase
  end

  tpcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Endpoint state: cleared by reset, moved only by a calibrate word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_x_q <= '0;
      far_x_q  <= '0;
    end else if (state_q == tpcc_pkg::ST_UPD_WAIT && div_rsp.done) begin
      if (side_q) begin
        near_x_q <= upd_x;
      end else begin
        far_x_q <= upd_x;
      end
    end
  end

  // Working registers: payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= tpcc_pkg::cmd_e'(command_i);
      tx_q  <= target_x_i;
      ty_q  <= target_y_i;
    end
    if (state_q == tpcc_pkg::ST_SETUP) begin
      side_q <= side;
      den_q  <= den_sel;
      prod_q <= mul_p;
    end
    if (state_q == tpcc_pkg::ST_FRAC_WAIT && div_rsp.done) begin
      prod_q <= mul_p;
    end
    if (state_q == tpcc_pkg::ST_FRAC_START && span == '0) begin
      res_q <= near_x_q;
    end
    if (state_q == tpcc_pkg::ST_ROUND) begin
      res_q <= tpcc_pkg::sat16(interp_sum);
    end
  end

  // Output register: load the result word, hold it while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= res_q;
      out_near_q <= near_x_q;
      out_far_q  <= far_x_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign crosshair_x_o   = out_x_q;
  assign near_endpoint_o = out_near_q;
  assign far_endpoint_o  = out_far_q;

`ifndef SYNTH
  // The divider answers only while the sequencer waits for it.
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == tpcc_pkg::ST_UPD_WAIT || state_q == tpcc_pkg::ST_FRAC_WAIT))
    else $error("divider result arrived outside a wait state");

  // A query word never reaches the endpoint update.
  a_query_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpcc_pkg::ST_UPD_START) |-> (cmd_q == tpcc_pkg::CMD_CALIBRATE))
    else $error("endpoint update started for a query word");

  // Endpoints move only at the end of an update division.
  a_endpoint_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == tpcc_pkg::ST_UPD_WAIT && div_rsp.done) |=>
      ($stable(near_x_q) && $stable(far_x_q)))
    else $error("endpoint changed outside an update");
`endif

endmodule

// ----- verif/tpcc_xhair_checker.sv -----
// Checker for the two-point crosshair calibrator: tracks line registers and endpoints,
// predicts each result word and compares it. Depends on tpcc_pkg.
`timescale 1ns / 1ps

module tpcc_xhair_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        command_i,
  input  logic [15:0] target_x_i,
  input  logic [15:0] target_y_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] crosshair_x_i,
  input  logic [15:0] near_endpoint_i,
  input  logic [15:0] far_endpoint_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          mismatch_cnt_o,
  output int          xhair_in_flight_o
);

  typedef struct packed {
    logic [15:0] xhair;
    logic [15:0] near_x;
    logic [15:0] far_x;
  } xhair_word_t;

  logic signed [tpcc_pkg::XW-1:0] near_line, far_line;
  logic signed [tpcc_pkg::XW-1:0] near_end, far_end;
  xhair_word_t                    xhair_q[$];
  int                             mismatches = 0;

  assign mismatch_cnt_o = mismatches;

  task automatic report(input string msg);
    mismatches++;
    $display("[%0t] xhair check: %s", $time, msg);
  endtask

  // Rounded quotient, ties away from zero.
  function automatic longint round_div(input longint num, input longint den);
    longint a, b, q;
    a = (num < 0) ? -num : num;
    b = (den < 0) ? -den : den;
    q = (a + b / 2) / b;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic signed [tpcc_pkg::XW-1:0] clip_q214(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return tpcc_pkg::XW'(v);
  endfunction

  // X on the current line at height y, weight clamped to -0.25..1.25.
  function automatic logic signed [tpcc_pkg::XW-1:0] xhair_at(
    input logic signed [tpcc_pkg::XW-1:0] y);
    longint one, span, frac;
    one  = longint'(1) << tpcc_pkg::FRAC_BITS;
    span = longint'(far_line) - longint'(near_line);
    if (span == 0) return near_end;
    frac = round_div((longint'(y) - longint'(near_line)) * one, span);
    if (frac < -(one >> 2)) frac = -(one >> 2);
    else if (frac > one + (one >> 2)) frac = one + (one >> 2);
    return clip_q214(longint'(near_end) +
                     round_div(frac * (longint'(far_end) - longint'(near_end)), one));
  endfunction

  // Pull one endpoint so the line passes through the target.
  task automatic move_endpoint(input logic signed [tpcc_pkg::XW-1:0] tx,
                               input logic signed [tpcc_pkg::XW-1:0] ty);
    longint span, den;
    span = longint'(far_line) - longint'(near_line);
    if (2 * longint'(ty) > longint'(near_line) + longint'(far_line)) begin
      den = longint'(far_line) - longint'(ty);
      if (den != 0)
        near_end = clip_q214(longint'(far_end) -
                             round_div((longint'(far_end) - longint'(tx)) * span, den));
    end else begin
      den = longint'(ty) - longint'(near_line);
      if (den != 0)
        far_end = clip_q214(longint'(near_end) +
                            round_div((longint'(tx) - longint'(near_end)) * span, den));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    xhair_word_t w;
    if (!rst_ni) begin
      near_line = tpcc_pkg::NEAR_Y_RST;
      far_line  = tpcc_pkg::FAR_Y_RST;
      near_end  = '0;
      far_end   = '0;
      xhair_q.delete();
      xhair_in_flight_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (xhair_q.size() == 0) begin
          report($sformatf("result word x=%h near=%h far=%h with nothing in flight",
                           crosshair_x_i, near_endpoint_i, far_endpoint_i));
        end else begin
          w = xhair_q.pop_front();
          if (crosshair_x_i !== w.xhair)
            report($sformatf("crosshair_x %h, want %h", crosshair_x_i, w.xhair));
          if (near_endpoint_i !== w.near_x)
            report($sformatf("near_endpoint %h, want %h", near_endpoint_i, w.near_x));
          if (far_endpoint_i !== w.far_x)
            report($sformatf("far_endpoint %h, want %h", far_endpoint_i, w.far_x));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == tpcc_pkg::REG_NEAR_Y) near_line = pwdata_i[15:0];
        else                                    far_line  = pwdata_i[15:0];
      end
      if (in_valid_i && !in_stall_i) begin
        if (command_i == tpcc_pkg::CMD_CALIBRATE) move_endpoint(target_x_i, target_y_i);
        w.xhair  = xhair_at(target_y_i);
        w.near_x = near_end;
        w.far_x  = far_end;
        xhair_q.push_back(w);
      end
      xhair_in_flight_o <= xhair_q.size();
    end
  end

endmodule

// ----- verif/two_point_crosshair_calibrator_tb.sv -----
// Testbench top for the two-point crosshair calibrator: clock, reset, words, APB writes.
// Depends on tpcc_pkg, two_point_crosshair_calibrator and tpcc_xhair_checker.
`timescale 1ns / 1ps

module two_point_crosshair_calibrator_tb;

  localparam int RANDOM_PER_PHASE = 100;
  localparam int N_SETTINGS       = 9;

  // Line settings walked through after the reset-value phase; the last two are random.
  localparam int NEAR_SET [N_SETTINGS] = '{1638, -32768, 32767, 0, 16384, -8192, 100, 0, 0};
  localparam int FAR_SET  [N_SETTINGS] = '{-11469, 32767, -32768, 0, -16384, 8192, 101, 0, 0};

  logic        clk, rst_n;
  logic        in_valid, in_stall, command;
  logic [15:0] target_x, target_y;
  logic        out_valid, out_stall;
  logic [15:0] crosshair_x, near_endpoint, far_endpoint;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          mismatch_cnt, xhair_in_flight;

  // Line positions as last written, used to aim targets at the interesting spots.
  int cur_near = 1638;
  int cur_far  = -11469;

  two_point_crosshair_calibrator u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .target_x_i      (target_x),
    .target_y_i      (target_y),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .crosshair_x_o   (crosshair_x),
    .near_endpoint_o (near_endpoint),
    .far_endpoint_o  (far_endpoint),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  tpcc_xhair_checker u_chk (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .command_i         (command),
    .target_x_i        (target_x),
    .target_y_i        (target_y),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .crosshair_x_i     (crosshair_x),
    .near_endpoint_i   (near_endpoint),
    .far_endpoint_i    (far_endpoint),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .pready_i          (pready),
    .mismatch_cnt_o    (mismatch_cnt),
    .xhair_in_flight_o (xhair_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: the slowest legal run stays well below 3.5 ms.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Idle length: mostly short, now and then long.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 100);
  endfunction

  function automatic logic [15:0] clip16(input int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  // Result side: alternate calm stretches with bursts of stalls. No leg is
  // empty, so out_stall gets a single update per edge.
  initial begin
    int n;
    forever begin
      if ($urandom_range(0, 9) < 3) begin
        out_stall <= 1'b0;
        n = $urandom_range(20, 150);
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
        out_stall <= 1'b1;
        n = pause_len();
        repeat (n) @(posedge clk);
      end
    end
  end

  // Offer one word, idle first if allowed, and hold it until it is taken.
  task automatic send_word(input tpcc_pkg::cmd_e cmd, input logic [15:0] x,
                           input logic [15:0] y, input bit may_pause);
    int gap;
    gap = (may_pause && $urandom_range(0, 1)) ? pause_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    target_x <= x;
    target_y <= y;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every word in flight has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (xhair_in_flight != 0);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic write_reg(input logic idx, input int v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{16{v[15]}}, v[15:0]};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_x();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (r < 10) return clip16($urandom_range(0, 16384) - 8192);
    return 16'($urandom_range(0, 65535));
  endfunction

  // Aim at the lines, the midpoint, the extremes, the span between lines, or anywhere.
  function automatic logic [15:0] pick_y();
    int r, lo, hi, mid;
    r   = $urandom_range(0, 15);
    mid = (cur_near + cur_far) >>> 1;
    lo  = (cur_near < cur_far) ? cur_near : cur_far;
    hi  = (cur_near < cur_far) ? cur_far : cur_near;
    case (r)
      0:       return clip16(cur_near);
      1:       return clip16(cur_far);
      2:       return clip16(mid);
      3:       return clip16(mid + 1);
      4:       return 16'h8000;
      5:       return 16'h7fff;
      6, 7:    return clip16(cur_near + $urandom_range(0, 128) - 64);
      8, 9, 10, 11: return clip16(lo + $urandom_range(0, hi - lo));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Hit the lines, the midpoint and the field extremes under the current setting.
  task automatic edge_words();
    int mid;
    mid = (cur_near + cur_far) >>> 1;
    send_word(tpcc_pkg::CMD_CALIBRATE, pick_x(), clip16(cur_near), 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, pick_x(), clip16(cur_far), 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, pick_x(), clip16(mid), 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, pick_x(), clip16(mid + 1), 1'b1);
    send_word(tpcc_pkg::CMD_QUERY, pick_x(), clip16(mid), 1'b1);
    send_word(tpcc_pkg::CMD_QUERY, 16'h7fff, 16'h8000, 1'b1);
    send_word(tpcc_pkg::CMD_QUERY, 16'h8000, 16'h7fff, 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, 16'h7fff, 16'h7fff, 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, 16'h8000, 16'h8000, 1'b1);
  endtask

  task automatic random_words();
    tpcc_pkg::cmd_e cmd;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      cmd = ($urandom_range(0, 99) < 45) ? tpcc_pkg::CMD_CALIBRATE : tpcc_pkg::CMD_QUERY;
      // every third run of 25 words goes back to back
      send_word(cmd, pick_x(), pick_y(), ((i / 25) % 3) != 0);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid <= 1'b0;
    command  <= tpcc_pkg::CMD_QUERY;
    target_x <= '0;
    target_y <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset-value lines, endpoints at zero: queries on an untouched line,
    // both sides of the midpoint, saturating targets, weights past the clamp.
    send_word(tpcc_pkg::CMD_QUERY, 16'h8000, 16'h0000, 1'b1);
    send_word(tpcc_pkg::CMD_QUERY, 16'h7fff, 16'h7fff, 1'b1);
    send_word(tpcc_pkg::CMD_QUERY, 16'h0000, 16'h8000, 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, 16'h2000, 16'd1638, 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, 16'hf000, 16'hd333, 1'b1);
    send_word(tpcc_pkg::CMD_QUERY, 16'h1234, 16'hec00, 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, 16'h0800, 16'heccd, 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, 16'hf800, 16'heccc, 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, 16'h7fff, 16'h7fff, 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, 16'h8000, 16'h8000, 1'b1);
    send_word(tpcc_pkg::CMD_QUERY, 16'h5555, 16'h7fff, 1'b1);
    send_word(tpcc_pkg::CMD_QUERY, 16'haaaa, 16'h8000, 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, 16'h0000, 16'h0000, 1'b1);
    send_word(tpcc_pkg::CMD_CALIBRATE, 16'h8000, 16'd1638, 1'b1);
    send_word(tpcc_pkg::CMD_QUERY, 16'h0000, 16'd1638, 1'b1);
    random_words();

    for (int p = 0; p < N_SETTINGS; p++) begin
      drain();
      if (p >= 7) begin
        cur_near = $urandom_range(0, 65535) - 32768;
        cur_far  = $urandom_range(0, 65535) - 32768;
      end else begin
        cur_near = NEAR_SET[p];
        cur_far  = FAR_SET[p];
      end
      write_reg(tpcc_pkg::REG_NEAR_Y, cur_near);
      write_reg(tpcc_pkg::REG_FAR_Y, cur_far);
      edge_words();
      random_words();
    end

    // Let any stray result word show up before the verdict.
    drain();
    repeat (80) @(posedge clk);
    if (mismatch_cnt == 0 && xhair_in_flight == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/tpcc_pkg.sv
sv/tpcc_div.sv
sv/two_point_crosshair_calibrator.sv
verif/tpcc_xhair_checker.sv
verif/two_point_crosshair_calibrator_tb.sv
